>>> sv/lpfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpfd_pkg;

  // Frame parser phases
  localparam logic [2:0] PH_LEN    = 3'd0;
  localparam logic [2:0] PH_VER    = 3'd1;
  localparam logic [2:0] PH_UIDLEN = 3'd2;
  localparam logic [2:0] PH_UID    = 3'd3;
  localparam logic [2:0] PH_PLEN   = 3'd4;
  localparam logic [2:0] PH_PAY    = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  // Result kinds
  localparam logic [1:0] KIND_UID = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Input opcodes
  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Bytes in one length/version field
  localparam int unsigned FIELD_BYTES = 4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         out_byte;
    logic               last;
    logic signed [31:0] message_type;
    logic               truncated;
    logic [30:0]        frame_length;
  } result_t;

endpackage

`default_nettype wire

>>> sv/lpfd_core.sv
`timescale 1ns / 1ps
`default_nettype none

module lpfd_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire logic                   opcode,
  input  wire logic [7:0]             data_byte,
  input  wire logic [31:0]            protocol_version,
  output lpfd_pkg::result_t           result,
  output logic                        emit
);

  logic [2:0]  phase_r,      phase_nxt;
  logic [30:0] seen_r,       seen_nxt;
  logic [30:0] total_r,      total_nxt;
  logic [31:0] fshift_r,     fshift_nxt;
  logic [1:0]  fcount_r,     fcount_nxt;
  logic [30:0] remain_r,     remain_nxt;
  logic [31:0] type_acc_r,   type_acc_nxt;
  logic [2:0]  type_cnt_r,   type_cnt_nxt;
  logic        good_r,       good_nxt;

  logic [31:0] shifted;
  logic        fdone;
  logic [1:0]  fcount_adv;
  logic [30:0] clamped;
  logic        clr;

  always_comb begin
    shifted    = {fshift_r[23:0], data_byte};
    fdone      = (fcount_r == 2'(lpfd_pkg::FIELD_BYTES - 1));
    fcount_adv = fdone ? 2'd0 : fcount_r + 2'd1;
    clamped    = shifted[31] ? 31'd0 : shifted[30:0];

    phase_nxt    = phase_r;
    seen_nxt     = seen_r;
    total_nxt    = total_r;
    fshift_nxt   = fshift_r;
    fcount_nxt   = fcount_r;
    remain_nxt   = remain_r;
    type_acc_nxt = type_acc_r;
    type_cnt_nxt = type_cnt_r;
    good_nxt     = good_r;
    clr          = 1'b0;

    emit                = 1'b0;
    result.kind         = lpfd_pkg::KIND_UID;
    result.out_byte     = 8'd0;
    result.last         = 1'b0;
    result.message_type = '0;
    result.truncated    = 1'b0;
    result.frame_length = total_r;

    if (opcode == lpfd_pkg::OP_CLEAR) begin
      clr = 1'b1;
    end else if (phase_r == lpfd_pkg::PH_LEN) begin
      fshift_nxt = shifted;
      fcount_nxt = fcount_adv;
      if (fdone) begin
        if (shifted[31] || shifted[30:0] <= 31'(lpfd_pkg::FIELD_BYTES)) begin
          clr = 1'b1;
        end else begin
          total_nxt  = shifted[30:0];
          seen_nxt   = 31'(lpfd_pkg::FIELD_BYTES);
          fshift_nxt = '0;
          phase_nxt  = (shifted[30:0] < 31'(2 * lpfd_pkg::FIELD_BYTES)) ? lpfd_pkg::PH_SKIP
                                                                          : lpfd_pkg::PH_VER;
        end
      end
    end else begin
      seen_nxt = seen_r + 31'd1;
      case (phase_r)
        lpfd_pkg::PH_VER: begin
          fshift_nxt = shifted;
          fcount_nxt = fcount_adv;
          if (fdone) begin
            good_nxt  = (shifted == protocol_version);
            phase_nxt = (shifted == protocol_version) ? lpfd_pkg::PH_UIDLEN
                                                      : lpfd_pkg::PH_SKIP;
          end
        end
        lpfd_pkg::PH_UIDLEN: begin
          fshift_nxt = shifted;
          fcount_nxt = fcount_adv;
          if (fdone) begin
            remain_nxt = clamped;
            phase_nxt  = (clamped != 31'd0) ? lpfd_pkg::PH_UID : lpfd_pkg::PH_PLEN;
          end
        end
        lpfd_pkg::PH_UID: begin
          emit            = 1'b1;
          result.kind     = lpfd_pkg::KIND_UID;
          result.out_byte = data_byte;
          remain_nxt      = remain_r - 31'd1;
          if (remain_r == 31'd1) begin
            phase_nxt = lpfd_pkg::PH_PLEN;
          end
        end
        lpfd_pkg::PH_PLEN: begin
          fshift_nxt = shifted;
          fcount_nxt = fcount_adv;
          if (fdone) begin
            remain_nxt = clamped;
            phase_nxt  = (clamped != 31'd0) ? lpfd_pkg::PH_PAY : lpfd_pkg::PH_SKIP;
          end
        end
        lpfd_pkg::PH_PAY: begin
          emit            = 1'b1;
          result.kind     = lpfd_pkg::KIND_PAY;
          result.out_byte = data_byte;
          if (type_cnt_r < 3'(lpfd_pkg::FIELD_BYTES)) begin
            type_acc_nxt = {type_acc_r[23:0], data_byte};
            type_cnt_nxt = type_cnt_r + 3'd1;
          end
          remain_nxt = remain_r - 31'd1;
          if (remain_r == 31'd1) begin
            phase_nxt = lpfd_pkg::PH_SKIP;
          end
        end
        default: begin
        end
      endcase

      // Frame end: the length field decides, whatever the inner fields say.
      // A frame that ends on its last version byte already counts as good if the version matches.
      if (seen_nxt == total_r) begin
        if (good_nxt) begin
          if (!emit) begin
            result.kind     = lpfd_pkg::KIND_END;
            result.out_byte = 8'd0;
          end
          emit                = 1'b1;
          result.last         = 1'b1;
          result.message_type = (type_cnt_nxt == 3'(lpfd_pkg::FIELD_BYTES)) ? type_acc_nxt
                                                                             : '0;
          result.truncated    = (phase_nxt != lpfd_pkg::PH_SKIP);
        end
        clr = 1'b1;
      end
    end

    if (clr) begin
      phase_nxt    = lpfd_pkg::PH_LEN;
      seen_nxt     = '0;
      total_nxt    = '0;
      fshift_nxt   = '0;
      fcount_nxt   = '0;
      remain_nxt   = '0;
      type_acc_nxt = '0;
      type_cnt_nxt = '0;
      good_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lpfd_pkg::PH_LEN;
      seen_r     <= '0;
      total_r    <= '0;
      fshift_r   <= '0;
      fcount_r   <= '0;
      remain_r   <= '0;
      type_acc_r <= '0;
      type_cnt_r <= '0;
      good_r     <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      seen_r     <= seen_nxt;
      total_r    <= total_nxt;
      fshift_r   <= fshift_nxt;
      fcount_r   <= fcount_nxt;
      remain_r   <= remain_nxt;
      type_acc_r <= type_acc_nxt;
      type_cnt_r <= type_cnt_nxt;
      good_r     <= good_nxt;
    end
  end

endmodule

`default_nettype wire

>>> sv/lpfd_out_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module lpfd_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load,
  input  wire logic              emit,
  input  wire lpfd_pkg::result_t result,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output lpfd_pkg::result_t      out_data
);

  logic              vld_r;
  lpfd_pkg::result_t data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= emit;
    end else if (!out_stall) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> sv/length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// Length-prefixed frame deframer.
// Input channel (in_valid / in_stall): one stream byte or a clear opcode per item.
// Output channel (out_valid / out_stall): uid and payload bytes of frames whose
// version matches cfg register; the final item of a good frame has out_last set
// with message type and truncation flag. Frames with a bad version or a short
// length field produce no items.
// cfg_wr_en / cfg_wr_data write the expected protocol version (reset value 1);
// write it only while the block is idle.
// An accepted item lands in the input register and is parsed once the output
// register can take its result, which, if any, is loaded there and raises out_valid.
// Throughput: one item per cycle when the output is free; parser state, the
// input register and the output register each advance once per cycle.
// Reset (rst_n low, synchronous): parser waits for a length field, both
// registers empty, version back to 1.
// When the receiver stalls with a result held, the input register holds its
// item and in_stall rises once it is full; nothing is lost or repeated.
module length_prefixed_frame_deframer (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_opcode,
  input  wire logic [7:0]         in_data_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              out_kind,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  output logic signed [31:0]      out_message_type,
  output logic                    out_truncated,
  output logic [30:0]             out_frame_length,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data
);

  logic              in_vld_r;
  logic              in_op_r;
  logic [7:0]        in_byte_r;
  logic [31:0]       version_r;
  logic              advance;
  logic              emit;
  lpfd_pkg::result_t result;
  lpfd_pkg::result_t out_data;

  // Parse the held item whenever the output register can take its result
  assign advance  = in_vld_r && !(out_valid && out_stall);
  assign in_stall = in_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_op_r   <= in_opcode;
      in_byte_r <= in_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 32'd1;
    end else if (cfg_wr_en) begin
      version_r <= cfg_wr_data;
    end
  end

  lpfd_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .step             (advance),
    .opcode           (in_op_r),
    .data_byte        (in_byte_r),
    .protocol_version (version_r),
    .result           (result),
    .emit             (emit)
  );

  lpfd_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .emit      (emit),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign out_kind         = out_data.kind;
  assign out_byte         = out_data.out_byte;
  assign out_last         = out_data.last;
  assign out_message_type = out_data.message_type;
  assign out_truncated    = out_data.truncated;
  assign out_frame_length = out_data.frame_length;

endmodule

`default_nettype wire

>>> bench/length_prefixed_frame_deframer_tb.sv
`timescale 1ns / 1ps

module length_prefixed_frame_deframer_tb;

  // One stream item as the sender presents it
  typedef struct packed {
    logic       op;
    logic [7:0] b;
  } stream_item_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_opcode = lpfd_pkg::OP_DATA;
  logic [7:0]         in_data_byte = 8'h00;
  logic               out_stall = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [31:0]        cfg_wr_data = 32'h0;
  logic               in_stall;
  logic               out_valid;
  logic [1:0]         out_kind;
  logic [7:0]         out_byte;
  logic               out_last;
  logic signed [31:0] out_message_type;
  logic               out_truncated;
  logic [30:0]        out_frame_length;

  length_prefixed_frame_deframer uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_last         (out_last),
    .out_message_type (out_message_type),
    .out_truncated    (out_truncated),
    .out_frame_length (out_frame_length),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Bookkeeping
  stream_item_t      stream_q[$];         // items waiting for the sender
  lpfd_pkg::result_t expected_results[$]; // predicted deframer output, oldest first
  logic [7:0]        frame_buf[$];        // scratch for building one frame
  int unsigned  items_queued = 0;
  int unsigned  items_taken = 0;
  int unsigned  results_seen = 0;
  int unsigned  frames_built = 0;
  int unsigned  version_writes = 0;
  int unsigned  errors = 0;
  int unsigned  send_wait = 0;
  int unsigned  recv_wait = 0;
  bit           send_burst = 1'b0;
  bit           recv_burst = 1'b0;

  // ---------------------------------------------------------------------
  // Deframer prediction: own copy of the parser state and the version
  // register. Updated once per accepted item.
  // ---------------------------------------------------------------------
  logic [31:0] match_version = 32'd1;
  logic [2:0]  parse_phase = lpfd_pkg::PH_LEN;
  logic [31:0] seen_count = '0;
  logic [31:0] frame_len = '0;
  logic [31:0] field_reg = '0;
  logic [1:0]  field_cnt = '0;
  logic [31:0] sect_left = '0;
  logic [31:0] type_acc = '0;
  logic [2:0]  type_cnt = '0;
  logic        frame_ok = 1'b0;

  function automatic void drop_frame();
    parse_phase = lpfd_pkg::PH_LEN;
    seen_count  = '0;
    frame_len   = '0;
    field_reg   = '0;
    field_cnt   = '0;
    sect_left   = '0;
    type_acc    = '0;
    type_cnt    = '0;
    frame_ok    = 1'b0;
  endfunction

  // Shift a byte into the 32-bit field; true once four bytes are in
  function automatic bit shift_field(input logic [7:0] b);
    field_reg = {field_reg[23:0], b};
    if (field_cnt >= lpfd_pkg::FIELD_BYTES - 1) begin
      field_cnt = '0;
      return 1'b1;
    end
    field_cnt++;
    return 1'b0;
  endfunction

  function automatic void deframe_byte(input logic op, input logic [7:0] b);
    logic              emit;
    logic              done;
    lpfd_pkg::result_t r;
    emit = 1'b0;
    r    = '0;
    if (op == lpfd_pkg::OP_CLEAR) begin
      drop_frame();
      return;
    end
    // Length field: short or negative lengths eat just these four bytes
    if (parse_phase == lpfd_pkg::PH_LEN) begin
      if (shift_field(b)) begin
        if (field_reg[31] || field_reg <= lpfd_pkg::FIELD_BYTES) begin
          drop_frame();
        end else begin
          frame_len   = field_reg;
          seen_count  = lpfd_pkg::FIELD_BYTES;
          parse_phase = (field_reg < 2 * lpfd_pkg::FIELD_BYTES) ? lpfd_pkg::PH_SKIP
                                                                 : lpfd_pkg::PH_VER;
          field_reg   = '0;
        end
      end
      return;
    end
    seen_count++;
    r.kind = lpfd_pkg::KIND_UID;
    case (parse_phase)
      lpfd_pkg::PH_VER: begin
        if (shift_field(b)) begin
          frame_ok    = (field_reg == match_version);
          parse_phase = frame_ok ? lpfd_pkg::PH_UIDLEN : lpfd_pkg::PH_SKIP;
        end
      end
      lpfd_pkg::PH_UIDLEN: begin
        if (shift_field(b)) begin
          // negative inner length counts as empty
          sect_left   = field_reg[31] ? '0 : field_reg;
          parse_phase = (sect_left != 0) ? lpfd_pkg::PH_UID : lpfd_pkg::PH_PLEN;
        end
      end
      lpfd_pkg::PH_UID: begin
        emit = 1'b1;
        sect_left--;
        if (sect_left == 0) parse_phase = lpfd_pkg::PH_PLEN;
      end
      lpfd_pkg::PH_PLEN: begin
        if (shift_field(b)) begin
          sect_left   = field_reg[31] ? '0 : field_reg;
          parse_phase = (sect_left != 0) ? lpfd_pkg::PH_PAY : lpfd_pkg::PH_SKIP;
        end
      end
      lpfd_pkg::PH_PAY: begin
        emit   = 1'b1;
        r.kind = lpfd_pkg::KIND_PAY;
        if (type_cnt < lpfd_pkg::FIELD_BYTES) begin
          type_acc = {type_acc[23:0], b};
          type_cnt++;
        end
        sect_left--;
        if (sect_left == 0) parse_phase = lpfd_pkg::PH_SKIP;
      end
      default: begin
      end
    endcase
    r.out_byte     = emit ? b : 8'h00;
    r.frame_length = frame_len[30:0];
    done = (seen_count == frame_len);
    if (done && frame_ok) begin
      // frame end on a non-data byte turns into an end marker
      if (!emit) begin
        r.kind     = lpfd_pkg::KIND_END;
        r.out_byte = 8'h00;
      end
      r.last         = 1'b1;
      r.message_type = (type_cnt == lpfd_pkg::FIELD_BYTES) ? type_acc : '0;
      r.truncated    = (parse_phase != lpfd_pkg::PH_SKIP);
      emit           = 1'b1;
    end
    if (done) drop_frame();
    if (emit) expected_results.push_back(r);
  endfunction

  // ---------------------------------------------------------------------
  // Handshake helpers
  // ---------------------------------------------------------------------

  // Random per-item wait, drawn afresh for each item; now and then flips into a run with no waits
  function automatic int unsigned draw_wait(inout bit burst);
    if ($urandom_range(0, 31) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  task automatic note_error(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Sender: one item in flight, refilled from the stream queue.
  // in_valid is computed first and assigned once per edge.
  always @(posedge clk) begin : sender
    logic         nxt_valid;
    stream_item_t it;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        deframe_byte(in_opcode, in_data_byte);
        items_taken++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (send_wait != 0) begin
          send_wait--;
        end else if (stream_q.size() != 0) begin
          it = stream_q.pop_front();
          in_opcode    <= it.op;
          in_data_byte <= it.b;
          nxt_valid = 1'b1;
          send_wait = draw_wait(send_burst);
        end
      end
    end
    in_valid <= nxt_valid;
  end

  // Receiver: checks each accepted item against the oldest prediction,
  // then stalls a random number of cycles before taking the next one.
  always @(posedge clk) begin : receiver
    lpfd_pkg::result_t want;
    int unsigned       nxt_wait;
    nxt_wait = recv_wait;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          note_error($sformatf("result with nothing expected (kind %0d byte %02h)",
                               out_kind, out_byte));
        end else begin
          want = expected_results.pop_front();
          if (out_kind !== want.kind)
            note_error($sformatf("kind got %0d want %0d", out_kind, want.kind));
          if (out_byte !== want.out_byte)
            note_error($sformatf("byte got %02h want %02h", out_byte, want.out_byte));
          if (out_last !== want.last)
            note_error($sformatf("last got %0b want %0b", out_last, want.last));
          if (out_message_type !== want.message_type)
            note_error($sformatf("message type got %08h want %08h",
                                 out_message_type, want.message_type));
          if (out_truncated !== want.truncated)
            note_error($sformatf("truncated got %0b want %0b",
                                 out_truncated, want.truncated));
          if (out_frame_length !== want.frame_length)
            note_error($sformatf("frame length got %0d want %0d",
                                 out_frame_length, want.frame_length));
        end
        nxt_wait = draw_wait(recv_burst);
      end else if (nxt_wait != 0) begin
        nxt_wait--;
      end
    end
    recv_wait = nxt_wait;
    out_stall <= (nxt_wait != 0);
  end

  // ---------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [7:0] b);
    stream_q.push_back('{op: op, b: b});
    items_queued++;
  endtask

  task automatic queue_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) queue_item(lpfd_pkg::OP_DATA, w[8 * i +: 8]);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) frame_buf.push_back(w[8 * i +: 8]);
  endtask

  // Builds a frame with the given version and inner length fields. The
  // length field is shortened by cut and only that many bytes go out, so a
  // cut ends the frame early. broken sends a random prefix, then a clear.
  task automatic queue_frame(input logic [31:0] ver, input logic [31:0] uid_field,
                             input logic [31:0] pay_field, input int unsigned extra,
                             input int unsigned cut, input bit broken);
    int unsigned uid_n;
    int unsigned pay_n;
    int unsigned total;
    int unsigned n;
    uid_n = uid_field[31] ? 0 : uid_field;
    pay_n = pay_field[31] ? 0 : pay_field;
    total = 16 + uid_n + pay_n + extra - cut;
    frame_buf.delete();
    put_word(total);
    put_word(ver);
    put_word(uid_field);
    repeat (uid_n) frame_buf.push_back(8'($urandom_range(0, 255)));
    put_word(pay_field);
    repeat (pay_n) frame_buf.push_back(8'($urandom_range(0, 255)));
    repeat (extra) frame_buf.push_back(8'($urandom_range(0, 255)));
    n = broken ? $urandom_range(1, total - 1) : total;
    for (int i = 0; i < n; i++) queue_item(lpfd_pkg::OP_DATA, frame_buf[i]);
    if (broken) queue_item(lpfd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    frames_built++;
  endtask

  // Mostly good frames with random content; the rest is wrong versions,
  // early frame ends, aborted frames, bad length fields and junk.
  task automatic queue_random_frame();
    int unsigned pick;
    int unsigned uid_n;
    int unsigned pay_n;
    int unsigned extra;
    logic [31:0] uid_field;
    logic [31:0] pay_field;
    pick  = $urandom_range(0, 99);
    uid_n = $urandom_range(0, 6);
    pay_n = $urandom_range(0, 12);
    extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
    uid_field = ($urandom_range(0, 15) == 0) ? (32'h8000_0000 | $urandom) : uid_n;
    pay_field = ($urandom_range(0, 15) == 0) ? (32'h8000_0000 | $urandom) : pay_n;
    if (pick < 65) begin
      queue_frame(match_version, uid_field, pay_field, extra, 0, 1'b0);
    end else if (pick < 75) begin
      queue_frame(match_version ^ (32'h1 << $urandom_range(0, 31)), uid_n, pay_n,
                  extra, 0, 1'b0);
    end else if (pick < 85) begin
      queue_frame(match_version, uid_n, pay_n, extra,
                  $urandom_range(1, 11 + uid_n + pay_n + extra), 1'b0);
    end else if (pick < 90) begin
      queue_frame(match_version, uid_n, pay_n, extra, 0, 1'b1);
    end else if (pick < 95) begin
      if ($urandom_range(0, 1) == 0) queue_word($urandom_range(0, 4));
      else queue_word(32'h8000_0000 | $urandom);
    end else begin
      repeat ($urandom_range(0, 6)) queue_item(lpfd_pkg::OP_DATA, 8'($urandom_range(0, 255)));
      queue_item(lpfd_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    end
  endtask

  // Block is idle once every queued item is taken and every predicted
  // result has come out; a further wait then lets a trailing item clear the
  // input and output registers.
  task automatic wait_idle();
    while (items_taken != items_queued || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_version(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    match_version = v;
    version_writes++;
    cfg_wr_en <= 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin : main_seq
    logic [31:0] versions[6];
    int unsigned phase_start;
    bit          paused;
    versions = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
                 32'h0000_0000, 32'h0000_0001};
    versions[4] = $urandom;
    paused = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames, version still at its reset value
    queue_word(32'd3);                              // short length
    queue_word(32'd0);
    queue_word(32'h8000_0000);                      // negative length
    queue_frame(match_version, 2, 5, 0, 0, 1'b0);   // uid and payload, type set
    queue_frame(match_version, 0, 2, 0, 0, 1'b0);   // payload too short for type
    queue_frame(match_version, 0, 0, 0, 0, 1'b0);   // empty frame, end marker
    queue_frame(32'd2, 1, 4, 0, 0, 1'b0);           // version mismatch
    queue_frame(match_version, 32'hFFFF_FFFF, 4, 0, 0, 1'b0); // negative uid length
    queue_frame(match_version, 1, 32'h8000_0000, 0, 0, 1'b0); // negative payload length
    queue_frame(match_version, 10, 0, 0, 5, 1'b0);  // ends inside uid
    queue_frame(match_version, 0, 3, 0, 5, 1'b0);   // ends inside payload length
    queue_frame(match_version, 0, 0, 0, 6, 1'b0);   // ends inside uid length
    queue_frame(match_version, 1, 8, 0, 3, 1'b0);   // ends inside payload
    queue_frame(match_version, 0, 4, 3, 0, 1'b0);   // trailing bytes
    queue_frame(match_version, 0, 0, 0, 8, 1'b0);   // length 8, ends after version
    queue_frame(match_version, 0, 0, 0, 9, 1'b0);   // length 7
    queue_frame(match_version, 0, 0, 0, 11, 1'b0);  // length 5
    queue_frame(match_version, 2, 6, 0, 0, 1'b1);   // aborted by a clear
    // Largest frame length: a few results, then abandoned with a clear
    queue_word(32'h7FFF_FFFF);
    queue_word(match_version);
    queue_word(32'd2);
    queue_item(lpfd_pkg::OP_DATA, 8'h00);
    queue_item(lpfd_pkg::OP_DATA, 8'hFF);
    queue_item(lpfd_pkg::OP_CLEAR, 8'hA5);
    wait_idle();

    // Random frames under a sequence of version settings, extremes included
    foreach (versions[i]) begin
      write_version(versions[i]);
      phase_start = items_queued;
      while (items_queued - phase_start < 30) begin
        queue_random_frame();
        // one pause in the middle with the version left alone
        if (i == 2 && !paused && items_queued - phase_start >= 12) begin
          wait_idle();
          paused = 1'b1;
        end
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    $display("covered %0d stream items in %0d built frames plus short lengths, clears and junk",
             items_taken, frames_built);
    $display("checked %0d results across %0d protocol version settings",
             results_seen, version_writes + 1);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog, far above the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
